// File: hdl/ptlf_pkg.sv
// ----------------------------------------------------------------------------
// ptlf_pkg
// Shared constants, register indexes and types for the paging table block.
// ----------------------------------------------------------------------------
package ptlf_pkg;

    localparam int PAGES      = 64;
    localparam int FRAMES     = 16;
    localparam int PAGE_W     = $clog2(PAGES);
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int FCNT_W     = $clog2(FRAMES + 1);
    localparam int PCNT_W     = $clog2(PAGES + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd2;

    localparam logic POL_LRU  = 1'b0;
    localparam logic POL_FIFO = 1'b1;

    typedef enum logic [1:0] {
        ST_UNUSED   = 2'd0,
        ST_RESIDENT = 2'd1,
        ST_DISK     = 2'd2
    } page_st_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              is_write;
    } pt_req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic               write_back;
        logic               bad_page;
    } pt_rsp_t;

    // one page table entry, with list links for the residency order
    typedef struct packed {
        page_st_t           status;
        logic               dirty;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  prev;
        logic [PAGE_W-1:0]  next;
    } pte_t;

    typedef struct packed {
        logic status;
        logic dirty;
        logic frame;
        logic prev;
        logic next;
    } pte_mask_t;

    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        pte_mask_t         wr_mask;
        pte_t              wr_data;
    } mem_cmd_t;

    typedef struct packed {
        logic              policy;
        logic [PCNT_W-1:0] eff_pages;
        logic [FCNT_W-1:0] eff_frames;
    } cfg_t;

endpackage

// File: hdl/page_table_lru_fifo_replacement.sv
// ----------------------------------------------------------------------------
// page_table_lru_fifo_replacement
// Demand paging table with LRU or FIFO replacement over a linked residency list.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_stall    ptlf_pkg::pt_req_t (page_number, is_write)
//  rsp      out  rsp_valid/rsp_stall    ptlf_pkg::pt_rsp_t (frame .. bad_page)
//  cfg      in   cfg_we                 cfg_index, cfg_wdata
//
//  a bad page, a FIFO hit or an LRU hit on the tail page ends after the lookup
//  read; a miss on a free frame writes the new entry, linked behind the tail
//  unless the list is empty; a full miss first reads the head page as victim
//  and marks it on disk (no tail link if it was the only resident page); an LRU
//  hit elsewhere relinks the page at the tail; the steps share the single memory port
//  reset clears status and dirty through per-page valid bits, no clearing pass
//  a finished response sits in the output register while the next request runs
//  req_stall is high while a request is in progress
//
module page_table_lru_fifo_replacement (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ptlf_pkg::pt_req_t                   req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ptlf_pkg::pt_rsp_t                   rsp_data,
    input  logic                                cfg_we,
    input  logic [ptlf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptlf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration registers
    logic                            policy_reg;
    logic [ptlf_pkg::PCNT_W-1:0]     pages_reg;
    logic [ptlf_pkg::FCNT_W-1:0]     frames_reg;
    ptlf_pkg::cfg_t                  cfg;

    // output register
    logic                            rsp_valid_reg;
    ptlf_pkg::pt_rsp_t               rsp_data_reg;

    logic                            out_free;
    logic                            done;
    ptlf_pkg::pt_rsp_t               result;
    ptlf_pkg::mem_cmd_t              cmd;
    ptlf_pkg::pte_t                  rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= ptlf_pkg::POL_LRU;
            pages_reg  <= ptlf_pkg::PCNT_W'(ptlf_pkg::PAGES);
            frames_reg <= ptlf_pkg::FCNT_W'(ptlf_pkg::FRAMES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptlf_pkg::REG_POLICY: policy_reg <= cfg_wdata[0];
                ptlf_pkg::REG_PAGES:  pages_reg  <= cfg_wdata[ptlf_pkg::PCNT_W-1:0];
                ptlf_pkg::REG_FRAMES: frames_reg <= cfg_wdata[ptlf_pkg::FCNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // effective counts: pages clamp to the table size, frames to 1..FRAMES
    always_comb
    begin
        cfg.policy = policy_reg;
        if (pages_reg > ptlf_pkg::PCNT_W'(ptlf_pkg::PAGES))
            cfg.eff_pages = ptlf_pkg::PCNT_W'(ptlf_pkg::PAGES);
        else
            cfg.eff_pages = pages_reg;
        if (frames_reg == '0)
            cfg.eff_frames = ptlf_pkg::FCNT_W'(1);
        else if (frames_reg > ptlf_pkg::FCNT_W'(ptlf_pkg::FRAMES))
            cfg.eff_frames = ptlf_pkg::FCNT_W'(ptlf_pkg::FRAMES);
        else
            cfg.eff_frames = frames_reg;
    end

    // response slot frees when empty or being taken this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    ptlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .cmd       (cmd),
        .rd_data   (rd_data)
    );

    ptlf_pte_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

endmodule

// File: hdl/ptlf_pte_mem.sv
// ----------------------------------------------------------------------------
// ptlf_pte_mem
// Page table memory: field-masked write port, registered read port.
// ----------------------------------------------------------------------------
module ptlf_pte_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  ptlf_pkg::mem_cmd_t cmd,
    output ptlf_pkg::pte_t     rd_data
);

    ptlf_pkg::pte_t                 pte_mem [ptlf_pkg::PAGES];
    logic [ptlf_pkg::PAGES-1:0]     valid_reg;
    ptlf_pkg::pte_t                 rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (cmd.wr_mask.status) pte_mem[cmd.wr_addr].status <= cmd.wr_data.status;
            if (cmd.wr_mask.dirty)  pte_mem[cmd.wr_addr].dirty  <= cmd.wr_data.dirty;
            if (cmd.wr_mask.frame)  pte_mem[cmd.wr_addr].frame  <= cmd.wr_data.frame;
            if (cmd.wr_mask.prev)   pte_mem[cmd.wr_addr].prev   <= cmd.wr_data.prev;
            if (cmd.wr_mask.next)   pte_mem[cmd.wr_addr].next   <= cmd.wr_data.next;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= pte_mem[cmd.rd_addr];
        end
    end

    // status is always written together with dirty, which marks the entry live
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && cmd.wr_mask.status)
            begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_data = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_data.status = ptlf_pkg::ST_UNUSED;
            rd_data.dirty  = 1'b0;
        end
    end

endmodule

// File: hdl/ptlf_ctrl.sv
// ----------------------------------------------------------------------------
// ptlf_ctrl
// Access sequencer: lookup, victim read and linked-list updates.
// ----------------------------------------------------------------------------
module ptlf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ptlf_pkg::cfg_t      cfg,
    input  logic                req_valid,
    output logic                req_stall,
    input  ptlf_pkg::pt_req_t   req_data,
    input  logic                out_free,
    output logic                done,
    output ptlf_pkg::pt_rsp_t   result,
    output ptlf_pkg::mem_cmd_t  cmd,
    input  ptlf_pkg::pte_t      rd_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOOK = 9'b000000010,
        S_VICT = 9'b000000100,
        S_NEW  = 9'b000001000,
        S_A    = 9'b000010000,
        S_B    = 9'b000100000,
        S_C    = 9'b001000000,
        S_TAIL = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t                            state_reg, state_next;
    logic [ptlf_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic                              wr_reg, wr_next;
    logic                              bad_reg, bad_next;
    ptlf_pkg::pt_rsp_t                 res_reg, res_next;
    logic [ptlf_pkg::PAGE_W-1:0]       head_reg, head_next;
    logic [ptlf_pkg::PAGE_W-1:0]       tail_reg, tail_next;
    logic [ptlf_pkg::FCNT_W-1:0]       nf_reg, nf_next;
    logic [ptlf_pkg::PAGE_W-1:0]       prev_reg, prev_next;
    logic [ptlf_pkg::PAGE_W-1:0]       nxt_reg, nxt_next;
    logic                              empty_reg, empty_next;
    logic                              accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign done      = (state_reg == S_DONE);
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            nf_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            nf_reg    <= nf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        wr_reg    <= wr_next;
        bad_reg   <= bad_next;
        res_reg   <= res_next;
        prev_reg  <= prev_next;
        nxt_reg   <= nxt_next;
        empty_reg <= empty_next;
    end

    always_comb
    begin
        state_next = state_reg;
        page_next  = page_reg;
        wr_next    = wr_reg;
        bad_next   = bad_reg;
        res_next   = res_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        nf_next    = nf_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        empty_next = empty_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    page_next   = req_data.page_number;
                    wr_next     = req_data.is_write;
                    bad_next    = ({1'b0, req_data.page_number} >= cfg.eff_pages);
                    res_next    = '0;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = req_data.page_number;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (bad_reg)
                begin
                    res_next.bad_page = 1'b1;
                    state_next        = S_DONE;
                end
                else if (rd_data.status == ptlf_pkg::ST_RESIDENT)
                begin
                    res_next.hit   = 1'b1;
                    res_next.frame = rd_data.frame;
                    prev_next      = rd_data.prev;
                    nxt_next       = rd_data.next;
                    if (cfg.policy == ptlf_pkg::POL_LRU && page_reg != tail_reg)
                    begin
                        state_next = S_A;
                    end
                    else
                    begin
                        cmd.wr_en         = wr_reg;
                        cmd.wr_addr       = page_reg;
                        cmd.wr_mask.dirty = 1'b1;
                        cmd.wr_data.dirty = 1'b1;
                        state_next        = S_DONE;
                    end
                end
                else if (nf_reg < cfg.eff_frames)
                begin
                    res_next.frame = nf_reg[ptlf_pkg::FRAME_W-1:0];
                    nf_next        = nf_reg + 1'b1;
                    empty_next     = (nf_reg == '0);
                    state_next     = S_NEW;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = head_reg;
                    state_next  = S_VICT;
                end
            end
            S_VICT:
            begin
                res_next.evicted      = 1'b1;
                res_next.evicted_page = head_reg;
                res_next.write_back   = rd_data.dirty;
                res_next.frame        = rd_data.frame;
                cmd.wr_en             = 1'b1;
                cmd.wr_addr           = head_reg;
                cmd.wr_mask.status    = 1'b1;
                cmd.wr_mask.dirty     = 1'b1;
                cmd.wr_data.status    = ptlf_pkg::ST_DISK;
                cmd.wr_data.dirty     = 1'b0;
                empty_next            = (head_reg == tail_reg);
                head_next             = rd_data.next;
                state_next            = S_NEW;
            end
            S_NEW:
            begin
                cmd.wr_en          = 1'b1;
                cmd.wr_addr        = page_reg;
                cmd.wr_mask.status = 1'b1;
                cmd.wr_mask.dirty  = 1'b1;
                cmd.wr_mask.frame  = 1'b1;
                cmd.wr_mask.prev   = 1'b1;
                cmd.wr_data.status = ptlf_pkg::ST_RESIDENT;
                cmd.wr_data.dirty  = wr_reg;
                cmd.wr_data.frame  = res_reg.frame;
                cmd.wr_data.prev   = tail_reg;
                if (empty_reg)
                begin
                    head_next  = page_reg;
                    tail_next  = page_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_A:
            begin
                if (page_reg == head_reg)
                begin
                    head_next = nxt_reg;
                end
                else
                begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_addr      = prev_reg;
                    cmd.wr_mask.next = 1'b1;
                    cmd.wr_data.next = nxt_reg;
                end
                state_next = S_B;
            end
            S_B:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_addr      = nxt_reg;
                cmd.wr_mask.prev = 1'b1;
                cmd.wr_data.prev = prev_reg;
                state_next       = S_C;
            end
            S_C:
            begin
                cmd.wr_en         = 1'b1;
                cmd.wr_addr       = page_reg;
                cmd.wr_mask.prev  = 1'b1;
                cmd.wr_mask.dirty = wr_reg;
                cmd.wr_data.prev  = tail_reg;
                cmd.wr_data.dirty = 1'b1;
                state_next        = S_TAIL;
            end
            S_TAIL:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_addr      = tail_reg;
                cmd.wr_mask.next = 1'b1;
                cmd.wr_data.next = page_reg;
                tail_next        = page_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= ptlf_pkg::FCNT_W'(ptlf_pkg::FRAMES))
        else $error("free frame count past frame total");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_reg.bad_page) |->
        (res_reg.frame == '0 && !res_reg.hit && !res_reg.evicted))
        else $error("bad page result carries other flags");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !(res_reg.hit && res_reg.evicted))
        else $error("hit and eviction on one request");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOK))
        else $error("accepted request not looked up");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paging table: drives page requests through the
// valid/stall handshake, predicts each response with a behavioral page table
// and compares it field by field; walks LRU and FIFO over several sizes.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ptlf_pkg::pt_req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    ptlf_pkg::pt_rsp_t rsp_data;
    logic cfg_we;
    logic [ptlf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ptlf_pkg::CFG_DATA_W-1:0] cfg_wdata;

    page_table_lru_fifo_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the configuration and the page table
    logic                         sh_policy;
    logic [6:0]                   sh_pages;
    logic [4:0]                   sh_frames;
    ptlf_pkg::page_st_t           sh_status [ptlf_pkg::PAGES];
    logic                         sh_dirty  [ptlf_pkg::PAGES];
    logic [ptlf_pkg::FRAME_W-1:0] sh_frame  [ptlf_pkg::PAGES];
    logic [ptlf_pkg::PAGE_W-1:0]  sh_order  [$];
    int                           sh_next_free;

    ptlf_pkg::pt_rsp_t expected_rsps [$];
    int      errors;
    int      cycles;
    bit      quiet_rx;     // stretch with no receiver stalls
    bit      quiet_tx;     // stretch with no sender gaps

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // predict the response of one page access and update the shadow table
    function automatic ptlf_pkg::pt_rsp_t predict_access(ptlf_pkg::pt_req_t rq);
        ptlf_pkg::pt_rsp_t r;
        int eff_p;
        int eff_f;
        int pno;
        logic [ptlf_pkg::PAGE_W-1:0] victim;
        logic [ptlf_pkg::FRAME_W-1:0] fno;
        r = '0;
        pno = rq.page_number;
        eff_p = (sh_pages > ptlf_pkg::PAGES) ? ptlf_pkg::PAGES : sh_pages;
        eff_f = (sh_frames == 0) ? 1 :
                ((sh_frames > ptlf_pkg::FRAMES) ? ptlf_pkg::FRAMES : sh_frames);
        if (pno >= eff_p)
        begin
            r.bad_page = 1'b1;
            return r;
        end
        if (sh_status[pno] == ptlf_pkg::ST_RESIDENT)
        begin
            r.hit = 1'b1;
            if (sh_policy == ptlf_pkg::POL_LRU)
            begin
                for (int i = 0; i < sh_order.size(); i++)
                begin
                    if (sh_order[i] == rq.page_number)
                    begin
                        sh_order.delete(i);
                        break;
                    end
                end
                sh_order.push_back(rq.page_number);
            end
            r.frame = sh_frame[pno];
        end
        else
        begin
            if (sh_next_free < eff_f)
            begin
                fno = ptlf_pkg::FRAME_W'(sh_next_free);
                sh_next_free++;
            end
            else
            begin
                victim = sh_order.pop_front();
                r.evicted = 1'b1;
                r.evicted_page = victim;
                r.write_back = sh_dirty[victim];
                fno = sh_frame[victim];
                sh_status[victim] = ptlf_pkg::ST_DISK;
                sh_dirty[victim] = 1'b0;
            end
            if (sh_order.size() < ptlf_pkg::FRAMES)
                sh_order.push_back(rq.page_number);
            sh_status[pno] = ptlf_pkg::ST_RESIDENT;
            sh_frame[pno] = fno;
            r.frame = fno;
        end
        if (rq.is_write)
            sh_dirty[pno] = 1'b1;
        return r;
    endfunction

    // receiver: random stalls, compare each accepted response
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin
        ptlf_pkg::pt_rsp_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing expected: %p", rsp_data);
                errors++;
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (rsp_data.frame !== exp_r.frame)
                begin
                    $error("frame expected %0d got %0d", exp_r.frame, rsp_data.frame);
                    errors++;
                end
                if (rsp_data.hit !== exp_r.hit)
                begin
                    $error("hit expected %0d got %0d", exp_r.hit, rsp_data.hit);
                    errors++;
                end
                if (rsp_data.evicted !== exp_r.evicted)
                begin
                    $error("evicted expected %0d got %0d", exp_r.evicted, rsp_data.evicted);
                    errors++;
                end
                if (rsp_data.evicted_page !== exp_r.evicted_page)
                begin
                    $error("evicted_page expected %0d got %0d",
                           exp_r.evicted_page, rsp_data.evicted_page);
                    errors++;
                end
                if (rsp_data.write_back !== exp_r.write_back)
                begin
                    $error("write_back expected %0d got %0d",
                           exp_r.write_back, rsp_data.write_back);
                    errors++;
                end
                if (rsp_data.bad_page !== exp_r.bad_page)
                begin
                    $error("bad_page expected %0d got %0d", exp_r.bad_page, rsp_data.bad_page);
                    errors++;
                end
            end
        end
    end

    // send one request, with an optional random gap before it; valid stays
    // high after the accept so back to back requests need no second drive
    task automatic send_request(input logic [ptlf_pkg::PAGE_W-1:0] pno, input logic wr);
        ptlf_pkg::pt_req_t rq;
        rq.page_number = pno;
        rq.is_write = wr;
        while (!quiet_tx && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsps.push_back(predict_access(rq));
    endtask

    // wait until every response is back, then let the block settle
    task automatic drain;
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ptlf_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[ptlf_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            ptlf_pkg::REG_POLICY: sh_policy = val[0];
            ptlf_pkg::REG_PAGES:  sh_pages = val[6:0];
            ptlf_pkg::REG_FRAMES: sh_frames = val[4:0];
            default:    ;
        endcase
    endtask

    // fill, hit, write and evict under the reset settings, plus edge pages
    task automatic test_directed;
        send_request(6'd0, 1'b1);
        send_request(6'd63, 1'b0);
        send_request(6'd0, 1'b0);           // hit, lru relink
        for (int p = 1; p < 16; p++)
            send_request(p[5:0], p[0]);     // fills frames, last one evicts
        send_request(6'd42, 1'b1);          // eviction of a dirty page
        send_request(6'd63, 1'b1);
        drain();
        write_reg(ptlf_pkg::REG_PAGES, 40);
        send_request(6'd40, 1'b1);          // out of range
        send_request(6'd63, 1'b0);
        send_request(6'd39, 1'b0);
        drain();
    endtask

    // random accesses over a small working set with some wide noise
    task automatic random_phase(input int n, input int span);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_request(ptlf_pkg::PAGE_W'($urandom_range(63)), 1'($urandom_range(1)));
            else
                send_request(ptlf_pkg::PAGE_W'($urandom_range(span - 1)),
                             1'($urandom_range(1)));
        end
        drain();
    endtask

    task automatic test_policy_lru;
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::POL_LRU);
        write_reg(ptlf_pkg::REG_PAGES, 64);
        random_phase(100, 24);
    endtask

    task automatic test_policy_fifo;
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::POL_FIFO);
        random_phase(100, 24);
    endtask

    // frame count lowered below what is allocated, and zero acts as one
    task automatic test_frame_limits;
        write_reg(ptlf_pkg::REG_FRAMES, 0);
        random_phase(60, 20);
        write_reg(ptlf_pkg::REG_FRAMES, 31);
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::POL_LRU);
        random_phase(60, 30);
        write_reg(ptlf_pkg::REG_FRAMES, 3);
        random_phase(60, 8);
    endtask

    // page count extremes: zero, one, above the table size, and a bogus index
    task automatic test_page_limits;
        write_reg(ptlf_pkg::REG_PAGES, 0);
        random_phase(10, 4);
        write_reg(ptlf_pkg::REG_PAGES, 1);
        random_phase(20, 2);
        write_reg(ptlf_pkg::REG_PAGES, 127);
        write_reg(2'd3, 5);
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::POL_FIFO);
        random_phase(60, 64);
    endtask

    // long stretch without idling on either side
    task automatic test_back_to_back;
        quiet_rx = 1'b1;
        quiet_tx = 1'b1;
        write_reg(ptlf_pkg::REG_POLICY, ptlf_pkg::POL_LRU);
        random_phase(100, 20);
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
        sh_policy = ptlf_pkg::POL_LRU;
        sh_pages = 7'd64;
        sh_frames = 5'd16;
        sh_next_free = 0;
        for (int i = 0; i < ptlf_pkg::PAGES; i++)
        begin
            sh_status[i] = ptlf_pkg::ST_UNUSED;
            sh_dirty[i] = 1'b0;
            sh_frame[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_policy_lru();
        test_policy_fifo();
        test_frame_limits();
        test_page_limits();
        test_back_to_back();

        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
